// ===== rtl/gps_binary_frame_parser_top_assert.svh =====
// ----------------------------------------------------------------------------
// gps binary frame parser assertion macros
// shared concurrent check forms, clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef GPS_BINARY_FRAME_PARSER_TOP_ASSERT_SVH
`define GPS_BINARY_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define GBFP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GBFP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfp_pkg
// shared types, constants and field selection for the gps frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package gbfp_pkg;

	localparam logic [7:0] SYNC0_BYTE = 8'hA0;
	localparam logic [7:0] SYNC1_BYTE = 8'hA2;
	localparam logic [7:0] END0_BYTE  = 8'hB0;
	localparam logic [7:0] NAV_ID_RST = 8'h02;
	localparam logic [7:0] GEO_ID_RST = 8'h29;

	localparam logic       CFG_NAV_ID = 1'b0;
	localparam logic       CFG_GEO_ID = 1'b1;

	localparam logic [6:0] NAV_SLOTS = 7'd42;
	localparam logic [6:0] GEO_SLOTS = 7'd92;
	localparam logic [6:0] IDX_MAX   = 7'd127;

	localparam logic [4:0] LAST_FIELD = 5'd17;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][15:0] vel;
		logic [2:0][7:0]  mas;
		logic [2:0][31:0] geo_long;
		logic [4:0][15:0] geo_short;
		logic [7:0]       hdop;
	} snap_t;

	typedef struct packed {
		snap_t data;
		logic  cap;
	} snap_req_t;

	function automatic logic [31:0] field_value_of(input snap_t s, input logic [4:0] f);
		logic [31:0] v;
		v = 32'd0;
		case (f)
			5'd0:    v = s.pos[0];
			5'd1:    v = s.pos[1];
			5'd2:    v = s.pos[2];
			5'd3:    v = {16'd0, s.vel[0]};
			5'd4:    v = {16'd0, s.vel[1]};
			5'd5:    v = {16'd0, s.vel[2]};
			5'd6:    v = {24'd0, s.mas[0]};
			5'd7:    v = {24'd0, s.mas[1]};
			5'd8:    v = {24'd0, s.mas[2]};
			5'd9:    v = {16'd0, s.geo_short[0]};
			5'd10:   v = {16'd0, s.geo_short[1]};
			5'd11:   v = s.geo_long[0];
			5'd12:   v = s.geo_long[1];
			5'd13:   v = s.geo_long[2];
			5'd14:   v = {16'd0, s.geo_short[2]};
			5'd15:   v = {16'd0, s.geo_short[3]};
			5'd16:   v = {16'd0, s.geo_short[4]};
			default: v = {24'd0, s.hdop};
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gbfp_front.sv =====
// ----------------------------------------------------------------------------
// gbfp_front
// byte-level frame tracker and field capture, hands snapshots to the back end
// ----------------------------------------------------------------------------
`default_nettype none

module gbfp_front import gbfp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,    // rx_byte
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_wdata,
	output logic            snap_valid,
	output snap_req_t       snap_req,
	input  wire logic       snap_ready
);

	typedef enum logic [3:0] {
		ST_HUNT, ST_GOT_A0, ST_LEN_HI, ST_LEN_LO, ST_MSGID,
		ST_NAV, ST_GEO, ST_SKIP, ST_GOT_B0
	} state_t;

	state_t      state_q;
	logic [7:0]  nav_id_q;
	logic [7:0]  geo_id_q;
	logic [7:0]  len_hi_q;
	logic [16:0] bytes_left_q;
	logic [6:0]  idx_q;
	snap_t       cap_q;

	logic        trig;
	logic        accept;
	logic [6:0]  vel_off;
	logic [6:0]  ll_off;
	logic [6:0]  alt_off;
	logic [6:0]  sg_off;
	logic [6:0]  clb_off;
	logic [2:0]  sg_word;

	assign trig       = (state_q == ST_GEO) && (bytes_left_q == 17'd0);
	assign s_tready   = !trig || snap_ready;
	assign accept     = s_tvalid && s_tready;
	assign snap_valid = accept && trig;
	assign snap_req.data = cap_q;
	assign snap_req.cap  = (cap_q.geo_short[0] == 16'd0);

	always_comb begin
		vel_off = idx_q - 7'd12;
		ll_off  = idx_q - 7'd22;
		alt_off = idx_q - 7'd34;
		sg_off  = idx_q - 7'd39;
		clb_off = idx_q - 7'd45;
		sg_word = 3'd2 + {2'd0, sg_off[1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_HUNT;
			nav_id_q     <= NAV_ID_RST;
			geo_id_q     <= GEO_ID_RST;
			len_hi_q     <= 8'd0;
			bytes_left_q <= 17'd0;
			idx_q        <= 7'd0;
			cap_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NAV_ID: nav_id_q <= cfg_wdata;
					CFG_GEO_ID: geo_id_q <= cfg_wdata;
					default:    ;
				endcase
			end
			if (accept) begin
				unique case (state_q)
					ST_HUNT: begin
						if (s_tdata == SYNC0_BYTE) state_q <= ST_GOT_A0;
					end
					ST_GOT_A0: begin
						if (s_tdata == SYNC1_BYTE) begin
							idx_q   <= 7'd0;
							state_q <= ST_LEN_HI;
						end else begin
							state_q <= ST_HUNT;
						end
					end
					ST_LEN_HI: begin
						len_hi_q <= s_tdata;
						state_q  <= ST_LEN_LO;
					end
					ST_LEN_LO: begin
						bytes_left_q <= {1'b0, len_hi_q, s_tdata} + 17'd1;
						state_q      <= ST_MSGID;
					end
					ST_MSGID: begin
						if (s_tdata == nav_id_q)      state_q <= ST_NAV;
						else if (s_tdata == geo_id_q) state_q <= ST_GEO;
						else                          state_q <= ST_SKIP;
					end
					ST_NAV, ST_GEO, ST_SKIP: begin
						if (bytes_left_q != 17'd0) begin
							if (state_q == ST_NAV && idx_q < NAV_SLOTS) begin
								if (idx_q < 7'd12)
									cap_q.pos[idx_q[3:2]][{~idx_q[1:0], 3'b000} +: 8]
										<= s_tdata;
								else if (idx_q < 7'd18)
									cap_q.vel[vel_off[2:1]][{~vel_off[0], 3'b000} +: 8]
										<= s_tdata;
								else if (idx_q == 7'd18)
									cap_q.mas[0] <= s_tdata;
								else if (idx_q == 7'd20)
									cap_q.mas[1] <= s_tdata;
								else if (idx_q == 7'd27)
									cap_q.mas[2] <= s_tdata;
							end else if (state_q == ST_GEO && idx_q < GEO_SLOTS) begin
								if (idx_q < 7'd4)
									cap_q.geo_short[{2'd0, idx_q[1]}][{~idx_q[0], 3'b000} +: 8]
										<= s_tdata;
								else if (idx_q >= 7'd22 && idx_q < 7'd30)
									cap_q.geo_long[{1'b0, ll_off[2]}][{~ll_off[1:0], 3'b000} +: 8]
										<= s_tdata;
								else if (idx_q >= 7'd34 && idx_q < 7'd38)
									cap_q.geo_long[2][{~alt_off[1:0], 3'b000} +: 8] <= s_tdata;
								else if (idx_q >= 7'd39 && idx_q < 7'd43)
									cap_q.geo_short[sg_word][{~sg_off[0], 3'b000} +: 8]
										<= s_tdata;
								else if (idx_q == 7'd45 || idx_q == 7'd46)
									cap_q.geo_short[4][{~clb_off[0], 3'b000} +: 8] <= s_tdata;
								else if (idx_q == 7'd88)
									cap_q.hdop <= s_tdata;
							end
							if (state_q != ST_SKIP && idx_q < IDX_MAX)
								idx_q <= idx_q + 7'd1;
							bytes_left_q <= bytes_left_q - 17'd1;
						end else begin
							state_q <= (s_tdata == END0_BYTE) ? ST_GOT_B0 : ST_HUNT;
						end
					end
					default: state_q <= ST_HUNT;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gbfp_emit.sv =====
// ----------------------------------------------------------------------------
// gbfp_emit
// one-deep snapshot buffer and field sequencer driving the output register
// ----------------------------------------------------------------------------
`default_nettype none

module gbfp_emit import gbfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        snap_valid,
	input  wire snap_req_t   snap_req,
	output logic             snap_ready,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // field_value
	output logic [5:0]       m_tuser,   // field_id[4:0], nav_ok
	output logic             m_tlast    // last
);

	snap_t       buf_q;
	logic        cap_q;
	logic        busy_q;
	logic [4:0]  idx_q;
	logic        vld_q;
	logic [31:0] val_q;
	logic [4:0]  fid_q;
	logic        ncap_q;
	logic        last_q;
	logic        load;

	assign snap_ready = !busy_q;
	assign load       = busy_q && (!vld_q || m_tready);

	assign m_tvalid = vld_q;
	assign m_tdata  = val_q;
	assign m_tuser  = {ncap_q, fid_q};
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 5'd0;
			vld_q  <= 1'b0;
		end else begin
			if (snap_valid && !busy_q) begin
				busy_q <= 1'b1;
				idx_q  <= 5'd0;
			end
			if (load) begin
				vld_q <= 1'b1;
				if (idx_q == LAST_FIELD) begin
					busy_q <= 1'b0;
					idx_q  <= 5'd0;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && !busy_q) begin
			buf_q <= snap_req.data;
			cap_q <= snap_req.cap;
		end
		if (load) begin
			val_q  <= field_value_of(buf_q, idx_q);
			fid_q  <= idx_q;
			ncap_q <= cap_q;
			last_q <= (idx_q == LAST_FIELD);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gps_binary_frame_parser_top.sv =====
// handoff: on the terminating byte the snapshot is buffered in the emit sequencer, then its first field is registered
// throughput: one received byte per cycle while s_tready is high; a snapshot drains at one field per cycle
// (18 fields) while m_tready is high, set by the single output register of the emit sequencer
// a geodetic frame end stalls input only while the previous snapshot still drains
// reset: asynchronous, active low; parser hunts for a0, captures clear to zero,
// message ids return to 2 and 41
// ----------------------------------------------------------------------------
// gps_binary_frame_parser_top
// binary gps frame parser with field capture and snapshot output stream
// ----------------------------------------------------------------------------
`default_nettype none

module gps_binary_frame_parser_top import gbfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // field_value
	output logic [5:0]       m_tuser,   // field_id[4:0], nav_ok
	output logic             m_tlast,   // last
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_wdata
);

	`include "gps_binary_frame_parser_top_assert.svh"

	logic      snap_valid;
	logic      snap_ready;
	snap_req_t snap_req;

	gbfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.snap_valid (snap_valid),
		.snap_req   (snap_req),
		.snap_ready (snap_ready)
	);

	gbfp_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_req   (snap_req),
		.snap_ready (snap_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// snapshot handoff leaves the back end busy
	`GBFP_ASSERT_NXT(a_snap_busy, snap_valid && snap_ready, !snap_ready, "snapshot buffer not held")
	// input stalls only for a snapshot the back end cannot take
	`GBFP_ASSERT_IMP(a_stall_cause, !s_tready, !snap_ready, "input stalled with free buffer")
	// last marks exactly the final field
	`GBFP_ASSERT_IMP(a_last_id, m_tvalid && m_tlast, m_tuser[4:0] == LAST_FIELD, "last on wrong field")
	`GBFP_ASSERT_IMP(a_id_last, m_tvalid && m_tuser[4:0] == LAST_FIELD, m_tlast, "final field not last")

endmodule

`default_nettype wire
